// ===== design/cuckoo_hash_set_defines.svh =====
// Assertion macros shared by the cuckoo hash set RTL.
`ifndef CUCKOO_HASH_SET_DEFINES_SVH
`define CUCKOO_HASH_SET_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define CHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define CHS_ASSERT_NEVER(lbl, cond, msg) \
    `CHS_ASSERT(lbl, !(cond), msg)
`else
`define CHS_ASSERT(lbl, prop, msg)
`define CHS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/chs_pkg.sv =====
// Types, widths and codes shared by the cuckoo hash set modules.
`timescale 1ns / 1ps
package chs_pkg;

    // Table depth must be a power of two; index is the low bits of key + offset.
    // The index width may not exceed the offset width.
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int KICK_W      = 8;
    localparam int OFFSET_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes
    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;

    // Result status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_MISS  = 2'd1;
    localparam status_t STATUS_LIMIT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET = 2'd2;

    localparam logic [KICK_W-1:0]   MAX_KICKS_RESET    = 8'd50;
    localparam logic [OFFSET_W-1:0] LEFT_OFFSET_RESET  = 16'd2;
    localparam logic [OFFSET_W-1:0] RIGHT_OFFSET_RESET = 16'd3;

    typedef struct packed {
        logic [KICK_W-1:0]   max_kicks;
        logic [OFFSET_W-1:0] left_offset;
        logic [OFFSET_W-1:0] right_offset;
    } cfg_t;

    // One access to a table: read at addr, optionally writing wdata there too
    typedef struct packed {
        logic en;
        logic we;
        idx_t addr;
        key_t wdata;
    } tbl_req_t;

endpackage

// ===== design/chs_slot.sv =====
// Shared slot unit: table index of a key for a given offset.
`timescale 1ns / 1ps
module chs_slot
(
    input  chs_pkg::key_t                  key,
    input  logic [chs_pkg::OFFSET_W-1:0]   offset,
    output chs_pkg::idx_t                  idx
);
    import chs_pkg::*;

    // (key + offset) mod depth keeps only the low index bits of the sum
    assign idx = key[IDX_W-1:0] + offset[IDX_W-1:0];

endmodule

// ===== design/chs_table.sv =====
// One hash table: single-address memory with per-entry valid bits.
`timescale 1ns / 1ps
module chs_table
(
    input  logic              clk,
    input  logic              rst_n,
    input  chs_pkg::tbl_req_t req,
    output chs_pkg::key_t     rdata
);
    import chs_pkg::*;

    key_t                   mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    key_t                   mem_q_reg;
    logic                   vld_q_reg;

    // Storage and registered read; a read in the write cycle sees the old word
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            mem_q_reg <= mem[req.addr];
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
        end
    end

    // Valid bits, cleared by reset so the table starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else if (req.en)
        begin
            vld_q_reg <= valid_reg[req.addr];
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
        end
    end

    // Entry never written reads as empty
    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

// ===== design/chs_ctrl.sv =====
// Sequencer: membership check, removal and eviction loop over both tables.
`timescale 1ns / 1ps
`include "cuckoo_hash_set_defines.svh"
module chs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  chs_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  chs_pkg::op_t      in_op,
    input  chs_pkg::key_t     in_key,
    output logic              out_valid,
    input  logic              out_ready,
    output chs_pkg::status_t  out_status,
    output chs_pkg::key_t     out_home,
    output chs_pkg::key_t     slot_key,
    output logic [chs_pkg::OFFSET_W-1:0] slot_off,
    input  chs_pkg::idx_t     slot_idx,
    output chs_pkg::tbl_req_t tbl_a,
    input  chs_pkg::key_t     rd_a,
    output chs_pkg::tbl_req_t tbl_b,
    input  chs_pkg::key_t     rd_b
);
    import chs_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        RD_A,
        RD_B,
        CHECK,
        KICK_A,
        CHK_A,
        KICK_B,
        CHK_B,
        DONE
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    key_t                key_reg, key_next;
    key_t                carry_reg, carry_next;
    logic [KICK_W-1:0]   round_reg, round_next;
    logic [KICK_W-1:0]   round_inc;
    idx_t                a_idx_reg, a_idx_next;
    idx_t                b_idx_reg, b_idx_next;
    status_t             res_status_reg, res_status_next;
    key_t                res_home_reg, res_home_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    key_t                out_home_reg, out_home_next;
    logic                hit_a, hit_b;

    assign hit_a     = (rd_a == key_reg);
    assign hit_b     = (rd_b == key_reg);
    assign round_inc = round_reg + {{(KICK_W-1){1'b0}}, 1'b1};

    // Next-state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        carry_next      = carry_reg;
        round_next      = round_reg;
        a_idx_next      = a_idx_reg;
        b_idx_next      = b_idx_reg;
        res_status_next = res_status_reg;
        res_home_next   = res_home_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_home_next   = out_home_reg;
        tbl_a           = '0;
        tbl_b           = '0;
        slot_key        = key_reg;
        slot_off        = cfg.left_offset;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_op;
                    key_next        = in_key;
                    carry_next      = in_key;
                    round_next      = '0;
                    res_status_next = STATUS_MISS;
                    res_home_next   = '0;
                    state_next      = RD_A;
                end
            end
            // read first-table candidate
            RD_A:
            begin
                tbl_a.en   = 1'b1;
                tbl_a.addr = slot_idx;
                a_idx_next = slot_idx;
                state_next = RD_B;
            end
            // read second-table candidate
            RD_B:
            begin
                slot_off   = cfg.right_offset;
                tbl_b.en   = 1'b1;
                tbl_b.addr = slot_idx;
                b_idx_next = slot_idx;
                state_next = CHECK;
            end
            // both candidates present: decide the operation
            CHECK:
            begin
                state_next = DONE;
                if (key_reg != '0)
                begin
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            if (hit_a || hit_b)
                            begin
                                res_status_next = STATUS_OK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit_a)
                            begin
                                tbl_a.en        = 1'b1;
                                tbl_a.we        = 1'b1;
                                tbl_a.addr      = a_idx_reg;
                                res_status_next = STATUS_OK;
                            end
                            else if (hit_b)
                            begin
                                tbl_b.en        = 1'b1;
                                tbl_b.we        = 1'b1;
                                tbl_b.addr      = b_idx_reg;
                                res_status_next = STATUS_OK;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (!(hit_a || hit_b))
                            begin
                                if (cfg.max_kicks == '0)
                                begin
                                    res_status_next = STATUS_LIMIT;
                                    res_home_next   = key_reg;
                                end
                                else
                                begin
                                    state_next = KICK_A;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // place carried key in first table, reading the resident
            KICK_A:
            begin
                slot_key    = carry_reg;
                tbl_a.en    = 1'b1;
                tbl_a.we    = 1'b1;
                tbl_a.addr  = slot_idx;
                tbl_a.wdata = carry_reg;
                state_next  = CHK_A;
            end
            CHK_A:
            begin
                if (rd_a == '0)
                begin
                    res_status_next = STATUS_OK;
                    state_next      = DONE;
                end
                else
                begin
                    carry_next = rd_a;
                    state_next = KICK_B;
                end
            end
            // move evicted key to its second-table slot
            KICK_B:
            begin
                slot_key    = carry_reg;
                slot_off    = cfg.right_offset;
                tbl_b.en    = 1'b1;
                tbl_b.we    = 1'b1;
                tbl_b.addr  = slot_idx;
                tbl_b.wdata = carry_reg;
                state_next  = CHK_B;
            end
            // end of a round: done, out of rounds, or kick again
            CHK_B:
            begin
                if (rd_b == '0)
                begin
                    res_status_next = STATUS_OK;
                    state_next      = DONE;
                end
                else if (round_inc == cfg.max_kicks)
                begin
                    res_status_next = STATUS_LIMIT;
                    res_home_next   = rd_b;
                    state_next      = DONE;
                end
                else
                begin
                    carry_next = rd_b;
                    round_next = round_inc;
                    state_next = KICK_A;
                end
            end
            // hand result to the output register once it is free
            DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_home_next   = res_home_reg;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            op_reg         <= OP_LOOKUP;
            key_reg        <= '0;
            carry_reg      <= '0;
            round_reg      <= '0;
            a_idx_reg      <= '0;
            b_idx_reg      <= '0;
            res_status_reg <= STATUS_MISS;
            res_home_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_MISS;
            out_home_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            carry_reg      <= carry_next;
            round_reg      <= round_next;
            a_idx_reg      <= a_idx_next;
            b_idx_reg      <= b_idx_next;
            res_status_reg <= res_status_next;
            res_home_reg   <= res_home_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_home_reg   <= out_home_next;
        end
    end

    assign in_ready   = (state_reg == IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_home   = out_home_reg;

    // Checks
    `CHS_ASSERT_NEVER(a_idle_no_write, (state_reg == IDLE) && (tbl_a.we || tbl_b.we), "table write while idle")
    `CHS_ASSERT(a_round_bound, (state_reg == KICK_A || state_reg == KICK_B) |-> (round_reg < cfg.max_kicks), "eviction round past limit")
    `CHS_ASSERT(a_home_zero, (out_valid_reg && (out_status_reg != STATUS_LIMIT)) |-> (out_home_reg == '0), "homeless key without kick limit")
    `CHS_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_reg == RD_A), "accepted request not started")

endmodule

// ===== design/cuckoo_hash_set.sv =====
// Two-table cuckoo hash set of 32-bit keys: top level.
//
// Requests arrive on the s_ channel: s_tuser carries the operation (lookup,
// insert, remove) and s_tdata the key. Key zero is reserved and always gives
// status 1. Each request yields exactly one result on the m_ channel:
// m_tuser carries the status, m_tdata the homeless key (nonzero only on
// kick-limit status).
// One request is processed at a time by a small sequencer around a shared
// slot adder and two single-port tables with registered reads. Lookups,
// removals and inserts of present keys pass through RD_A, RD_B, CHECK and
// DONE before the result is registered, and no new request is taken until
// then; an insert adds KICK_A/CHK_A for each first-table placement and
// KICK_B/CHK_B for each second-table placement, up to max_kicks rounds.
// s_tready is high again in the cycle the result appears.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; a second result then waits in the sequencer.
// Reset empties both tables at once through per-entry valid bits and sets
// max_kicks, left_offset and right_offset to 50, 2 and 3. The user must
// write cfg_we/cfg_index/cfg_data only while idle; it is not enforced.
`timescale 1ns / 1ps
module cuckoo_hash_set
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [chs_pkg::KEY_W-1:0]        s_tdata,   // [31:0] key
    input  logic [chs_pkg::OP_W-1:0]         s_tuser,   // [1:0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [chs_pkg::KEY_W-1:0]        m_tdata,   // [31:0] homeless_key
    output logic [chs_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    input  logic                             cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chs_pkg::CFG_W-1:0]        cfg_data
);
    import chs_pkg::*;

    cfg_t                cfg_reg;
    key_t                slot_key;
    logic [OFFSET_W-1:0] slot_off;
    idx_t                slot_idx;
    tbl_req_t            tbl_a;
    tbl_req_t            tbl_b;
    key_t                rd_a;
    key_t                rd_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_kicks    <= MAX_KICKS_RESET;
            cfg_reg.left_offset  <= LEFT_OFFSET_RESET;
            cfg_reg.right_offset <= RIGHT_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_KICKS:    cfg_reg.max_kicks    <= cfg_data[KICK_W-1:0];
                CFG_LEFT_OFFSET:  cfg_reg.left_offset  <= cfg_data[OFFSET_W-1:0];
                CFG_RIGHT_OFFSET: cfg_reg.right_offset <= cfg_data[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Shared slot adder
    chs_slot u_slot
    (
        .key    (slot_key),
        .offset (slot_off),
        .idx    (slot_idx)
    );

    // First and second tables
    chs_table u_first
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_a),
        .rdata (rd_a)
    );

    chs_table u_second
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_b),
        .rdata (rd_b)
    );

    // Request sequencer and output register
    chs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_key     (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_home   (m_tdata),
        .slot_key   (slot_key),
        .slot_off   (slot_off),
        .slot_idx   (slot_idx),
        .tbl_a      (tbl_a),
        .rd_a       (rd_a),
        .tbl_b      (tbl_b),
        .rd_b       (rd_b)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the two-table cuckoo hash set.
`timescale 1ns / 1ps
module testbench;
    import chs_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          POOL_SIZE     = 96;
    localparam int          GROUP_KEYS    = 24;     // pool keys that share slots, 4 per group
    localparam int          REPORT_LIMIT  = 10;
    localparam int unsigned TIMEOUT_NS    = 40_000_000;
    localparam op_t         OP_UNUSED     = 2'd3;

    typedef struct packed {
        status_t status;
        key_t    homeless;
    } outcome_t;

    // DUT ports; the inputs are known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata   = '0;   // [31:0] key
    logic [OP_W-1:0]      s_tuser   = '0;   // [1:0] op
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [KEY_W-1:0]     m_tdata;          // [31:0] homeless_key
    logic [STATUS_W-1:0]  m_tuser;          // [1:0] status
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Shadow copy of the set and its configuration
    key_t                 shadow_first  [TABLE_DEPTH];
    key_t                 shadow_second [TABLE_DEPTH];
    logic [KICK_W-1:0]    shadow_kicks     = MAX_KICKS_RESET;
    logic [OFFSET_W-1:0]  shadow_left_off  = LEFT_OFFSET_RESET;
    logic [OFFSET_W-1:0]  shadow_right_off = RIGHT_OFFSET_RESET;

    outcome_t             awaited_outcomes[$];
    key_t                 key_pool[POOL_SIZE];
    int                   failures     = 0;
    int                   tx_mode      = 0;  // 0 steady, 1 bursts with gaps
    int                   rx_mode      = 0;  // 0 always ready, 1 light stalls, 2 heavy stalls
    int                   burst_left   = 0;
    int                   hold_request = 0;

    cuckoo_hash_set dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 125 MHz clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Slot index: key + offset formed in 33 bits, then taken mod depth
    function automatic idx_t slot_for(key_t key, logic [OFFSET_W-1:0] offset);
        logic [KEY_W:0] sum;
        sum = {1'b0, key} + {{(KEY_W+1-OFFSET_W){1'b0}}, offset};
        return idx_t'(sum % (KEY_W+1)'(TABLE_DEPTH));
    endfunction

    // Apply one request to the shadow set and return the outcome it must give
    function automatic outcome_t set_outcome(op_t op, key_t key);
        outcome_t res;
        idx_t     a;
        idx_t     b;
        idx_t     s;
        key_t     carry;
        key_t     old;
        logic     member;
        logic     placed;
        res.status   = STATUS_MISS;
        res.homeless = '0;
        if (key != '0)
        begin
            a      = slot_for(key, shadow_left_off);
            b      = slot_for(key, shadow_right_off);
            member = (shadow_first[a] == key) || (shadow_second[b] == key);
            case (op)
                OP_LOOKUP:
                    res.status = member ? STATUS_OK : STATUS_MISS;
                OP_REMOVE:
                begin
                    if (shadow_first[a] == key)
                    begin
                        shadow_first[a] = '0;
                        res.status      = STATUS_OK;
                    end
                    else if (shadow_second[b] == key)
                    begin
                        shadow_second[b] = '0;
                        res.status       = STATUS_OK;
                    end
                end
                OP_INSERT:
                begin
                    if (!member)
                    begin
                        carry  = key;
                        placed = 1'b0;
                        // one round: place in first table, then the evictee in the second
                        for (int round = 0; round < int'(shadow_kicks) && !placed; round++)
                        begin
                            s               = slot_for(carry, shadow_left_off);
                            old             = shadow_first[s];
                            shadow_first[s] = carry;
                            carry           = old;
                            if (carry == '0)
                                placed = 1'b1;
                            else
                            begin
                                s                = slot_for(carry, shadow_right_off);
                                old              = shadow_second[s];
                                shadow_second[s] = carry;
                                carry            = old;
                                if (carry == '0)
                                    placed = 1'b1;
                            end
                        end
                        if (placed)
                            res.status = STATUS_OK;
                        else
                        begin
                            res.status   = STATUS_LIMIT;
                            res.homeless = carry;
                        end
                    end
                end
                default: ;  // unused op code changes nothing
            endcase
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Result checker: every transfer on the result side is compared in order
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_outcomes.size() == 0)
                note_failure($sformatf("unexpected result status=%0d key=%h", m_tuser, m_tdata));
            else
            begin
                want = awaited_outcomes.pop_front();
                if (m_tuser !== want.status)
                    note_failure($sformatf("status expected %0d got %0d", want.status, m_tuser));
                if (m_tdata !== want.homeless)
                    note_failure($sformatf("homeless_key expected %h got %h",
                                           want.homeless, m_tdata));
            end
        end
    end

    // Receiver: optional long hold-off, otherwise ready/stall runs of random length
    initial
    begin
        int   run_left;
        int   hold_left;
        logic ready_level;
        run_left    = 0;
        hold_left   = 0;
        ready_level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_mode == 0)
                m_tready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    ready_level = !ready_level;
                    run_left    = ready_level ? $urandom_range(1, 8)
                                              : $urandom_range(1, (rx_mode == 2) ? 24 : 5);
                end
                run_left--;
                m_tready <= ready_level;
            end
        end
    end

    // Offer one request and wait for its transfer; the prediction is made at acceptance
    task automatic send_request(input op_t op, input key_t key);
        int gap;
        if (tx_mode != 0 && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        awaited_outcomes.push_back(set_outcome(op, key));
    endtask

    // Stop sending and let every outstanding result arrive
    task automatic wait_for_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_MAX_KICKS:    shadow_kicks     = value[KICK_W-1:0];
            CFG_LEFT_OFFSET:  shadow_left_off  = value[OFFSET_W-1:0];
            CFG_RIGHT_OFFSET: shadow_right_off = value[OFFSET_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic write_config(input int kicks, input int left_off, input int right_off);
        write_register(CFG_MAX_KICKS, CFG_W'(kicks));
        write_register(CFG_LEFT_OFFSET, CFG_W'(left_off));
        write_register(CFG_RIGHT_OFFSET, CFG_W'(right_off));
    endtask

    // Fresh keys: groups of four sharing their low index bits, then fully random ones
    task automatic refill_key_pool();
        idx_t group_low;
        group_low = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i % 4 == 0)
                group_low = idx_t'($urandom);
            key_pool[i] = $urandom;
            if (i < GROUP_KEYS)
                key_pool[i][IDX_W-1:0] = group_low;
            if (key_pool[i] == '0)
                key_pool[i] = 32'h1;
        end
    endtask

    // Mostly insert/lookup/remove on pool keys; some random keys, key zero, unused op
    task automatic send_random_request();
        int   pick;
        int   kind;
        op_t  op;
        key_t key;
        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            kind = $urandom_range(0, 99);
            op   = (kind < 45) ? OP_INSERT : (kind < 75) ? OP_LOOKUP : OP_REMOVE;
        end
        else if (pick < 93)
        begin
            key = $urandom;
            op  = op_t'($urandom_range(0, 2));
        end
        else if (pick < 96)
        begin
            key = '0;
            op  = op_t'($urandom_range(0, 3));
        end
        else
        begin
            key = $urandom;
            op  = OP_UNUSED;
        end
        send_request(op, key);
    endtask

    // Reserved key, unused op, basic set operations, eviction and kick limit at defaults
    task automatic test_reserved_and_basic();
        key_t k;
        k = 32'h1234_5678;
        tx_mode = 0;
        rx_mode = 0;
        send_request(OP_LOOKUP, '0);
        send_request(OP_INSERT, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_UNUSED, '0);
        send_request(OP_UNUSED, 32'hDEAD_BEEF);
        send_request(OP_LOOKUP, k);
        send_request(OP_INSERT, k);
        send_request(OP_INSERT, k);               // already present
        send_request(OP_LOOKUP, k);
        send_request(OP_INSERT, 32'hFFFF_FFFF);   // sum needs the 33rd bit
        send_request(OP_INSERT, 32'h8000_0000);
        // the sender pauses until the set has answered everything
        wait_for_results();
        send_request(OP_INSERT, k + 32'd128);     // same slots: k moves to second table
        send_request(OP_LOOKUP, k);
        send_request(OP_REMOVE, k);               // removal from second table
        send_request(OP_REMOVE, k);
        send_request(OP_INSERT, k);
        send_request(OP_INSERT, k + 32'd256);     // three keys, two slots: kick limit
        send_request(OP_LOOKUP, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    // Zero and one kick allowed, then the largest settings
    task automatic test_kick_extremes();
        key_t k;
        k = 32'h0000_0A01;
        write_config(0, 0, 0);
        send_request(OP_INSERT, k);               // nothing stored, key itself homeless
        send_request(OP_LOOKUP, k);
        write_config(1, 0, 0);
        send_request(OP_INSERT, k);
        send_request(OP_INSERT, k + 32'd128);
        send_request(OP_INSERT, k + 32'd256);     // one round is not enough
        write_config(255, 65535, 65535);
        send_request(OP_INSERT, 32'hFFFF_FF81);
        send_request(OP_LOOKUP, 32'hFFFF_FF81);
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        wait_for_results();
        tx_mode      = 0;
        rx_mode      = 0;
        hold_request = 400;
        for (int i = 0; i < 40; i++)
            send_random_request();
        wait_for_results();
    endtask

    task automatic test_random_phase(input int count, input int kicks, input int left_off,
                                     input int right_off, input int tx, input int rx);
        write_config(kicks, left_off, right_off);
        refill_key_pool();
        tx_mode = tx;
        rx_mode = rx;
        for (int i = 0; i < count; i++)
            send_random_request();
        wait_for_results();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_first[i]  = '0;
            shadow_second[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reserved_and_basic();
        test_kick_extremes();
        test_random_phase(150, 50, 2, 3, 0, 0);
        test_random_phase(150, 1, 0, 0, 1, 1);
        test_random_phase(150, 255, 65535, 65535, 1, 2);
        test_random_phase(80, 0, $urandom_range(0, 65535), $urandom_range(0, 65535), 1, 1);
        test_backpressure();
        test_random_phase(200, $urandom_range(2, 20), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), 1, 1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
